// ===== rtl/spfc_pkg.sv =====
// shared types, constants and round functions for the sha-256 puzzle fold check
package spfc_pkg;

    localparam int unsigned ROUNDS = 64;

    typedef struct packed {
        logic [31:0] nonce_word;
        logic [31:0] seed_word;
        logic [31:0] server_address;
        logic [31:0] client_address;
        logic [7:0]  kind_byte;
        logic [31:0] difficulty_limit;
    } in_item_t;

    typedef struct packed {
        logic [31:0] folded_value;
        logic        below_limit;
    } out_item_t;

    // working variables a..h
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } work_t;

    // what one cell hands to the next
    typedef struct packed {
        logic            valid;
        work_t           work;
        logic [15:0][31:0] sched;
        logic [31:0]     limit;
    } cell_data_t;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] byte_swap(input logic [31:0] x);
        byte_swap = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ===== rtl/spfc_round_cell.sv =====
// one sha-256 round cell with its rolling message schedule window
module spfc_round_cell #(
    parameter int unsigned ROUND = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  spfc_pkg::cell_data_t    prev,
    output spfc_pkg::cell_data_t    cur
);
    import spfc_pkg::*;

    cell_data_t  cell_reg;
    cell_data_t  cell_next;
    logic [31:0] w;
    logic [31:0] s0w;
    logic [31:0] s1w;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] t1;
    logic [31:0] big_s0;
    logic [31:0] maj;

    always_comb
    begin
        w      = prev.sched[0];
        s0w    = rotr(prev.sched[1], 7) ^ rotr(prev.sched[1], 18) ^ (prev.sched[1] >> 3);
        s1w    = rotr(prev.sched[14], 17) ^ rotr(prev.sched[14], 19)
                 ^ (prev.sched[14] >> 10);
        big_s1 = rotr(prev.work.e, 6) ^ rotr(prev.work.e, 11) ^ rotr(prev.work.e, 25);
        ch     = (prev.work.e & prev.work.f) ^ (~prev.work.e & prev.work.g);
        t1     = prev.work.h + big_s1 + ch + ROUND_K[ROUND] + w;
        big_s0 = rotr(prev.work.a, 2) ^ rotr(prev.work.a, 13) ^ rotr(prev.work.a, 22);
        maj    = (prev.work.a & prev.work.b) ^ (prev.work.a & prev.work.c)
                 ^ (prev.work.b & prev.work.c);
        cell_next        = prev;
        cell_next.work.h = prev.work.g;
        cell_next.work.g = prev.work.f;
        cell_next.work.f = prev.work.e;
        cell_next.work.e = prev.work.d + t1;
        cell_next.work.d = prev.work.c;
        cell_next.work.c = prev.work.b;
        cell_next.work.b = prev.work.a;
        cell_next.work.a = t1 + big_s0 + maj;
        // window slides one word; new word is w[i+16]
        for (int k = 0; k < 15; k++)
        begin
            cell_next.sched[k] = prev.sched[k + 1];
        end
        cell_next.sched[15] = prev.sched[0] + s0w + prev.sched[9] + s1w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cur = cell_reg;

endmodule

// ===== rtl/spfc_fold_stage.sv =====
// final digest add, xor fold and threshold compare into the output register
module spfc_fold_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  spfc_pkg::cell_data_t    last,
    output logic                    out_valid,
    output spfc_pkg::out_item_t     result
);
    import spfc_pkg::*;

    logic [7:0][31:0] digest;
    logic [31:0]      folded;
    logic [255:0]     work_bits;
    logic             valid_reg;
    out_item_t        result_reg;
    out_item_t        result_next;

    always_comb
    begin
        work_bits = last.work;
        for (int k = 0; k < 8; k++)
        begin
            digest[7 - k] = work_bits[255 - 32*k -: 32] + INIT_H[255 - 32*k -: 32];
        end
        // result byte i folds digest words 2i and 2i+1
        for (int i = 0; i < 4; i++)
        begin
            folded[31 - 8*i -: 8] =
                digest[7 - 2*i][31:24] ^ digest[7 - 2*i][23:16]
                ^ digest[7 - 2*i][15:8] ^ digest[7 - 2*i][7:0]
                ^ digest[6 - 2*i][31:24] ^ digest[6 - 2*i][23:16]
                ^ digest[6 - 2*i][15:8] ^ digest[6 - 2*i][7:0];
        end
        result_next.folded_value = folded;
        result_next.below_limit  = folded < last.limit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/sha256_puzzle_fold_check_core.sv =====
// top level: message build, 64-cell round chain and fold stage
// Usage:
//   in channel: in_valid/in_stall carry one candidate (in_item_t) per transaction;
//   out channel: out_valid/out_stall carry the folded value and below-limit flag.
//   One transaction is accepted every cycle while the output is not stalled.
//   A candidate passes through one register per round cell of the 64-stage
//   chain and then the fold and compare register at the end.
//   Throughput is one candidate per cycle while the output is not stalled, set by the fully pipelined round chain.
//   in_stall is raised only while the output register holds a result that the
//   receiver stalls and the chain is full behind it; bubbles in the chain are
//   squeezed out so the block keeps accepting while a result waits.
//   The full stages behind a stalled result freeze while it blocks them; nothing is lost.
//   Reset clears every valid flag; the block is ready after reset release.
module sha256_puzzle_fold_check_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  spfc_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output spfc_pkg::out_item_t   out_data
);
    import spfc_pkg::*;

    cell_data_t chain [ROUNDS + 1];
    logic       adv [ROUNDS + 1];
    cell_data_t head;

    always_comb
    begin
        head.valid = in_valid;
        head.work  = INIT_H;
        head.limit = in_data.difficulty_limit;
        for (int k = 0; k < 16; k++)
        begin
            head.sched[k] = 32'h0;
        end
        head.sched[0]  = byte_swap(in_data.nonce_word);
        head.sched[1]  = byte_swap(in_data.seed_word);
        head.sched[2]  = byte_swap(in_data.server_address);
        head.sched[3]  = byte_swap(in_data.client_address);
        head.sched[4]  = {in_data.kind_byte, 8'h80, 16'h0000};
        head.sched[15] = 32'd136;
    end

    assign chain[0] = head;

    // a stage advances when the one after it advances or it holds nothing
    assign adv[ROUNDS] = !out_valid || !out_stall;

    genvar r;
    generate
        for (r = 0; r < ROUNDS; r++)
        begin : g_cell
            assign adv[r] = adv[r + 1] || !chain[r + 1].valid;
            spfc_round_cell #(.ROUND(r)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (adv[r]),
                .prev    (chain[r]),
                .cur     (chain[r + 1])
            );
        end
    endgenerate

    assign in_stall = !adv[0];

    spfc_fold_stage u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv[ROUNDS]),
        .last      (chain[ROUNDS]),
        .out_valid (out_valid),
        .result    (out_data)
    );

endmodule
